@@ hdl/lbtack_pkg.sv @@
package lbtack_pkg;

	// Upper bound on carrier sense attempts; the trial counter width follows it.
	localparam int unsigned TRIALS_BOUND = 8;
	localparam int unsigned TRIAL_W      = 3;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned RSSI_W   = 9;
	localparam int unsigned RND_W    = 8;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned TICKS_W  = 15;
	localparam int unsigned SENSE_W  = 10;
	localparam int unsigned UNIT_W   = 8;
	localparam int unsigned TRLIM_W  = 4;
	localparam int unsigned WDOG_W   = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Input event codes.
	localparam logic [CMD_W-1:0] CMD_MS_TICK    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SEC_TICK   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RX_DONE    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RX_TIMEOUT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RX_ERROR   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TX_DONE    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_TX_TIMEOUT = 3'd6;

	// Result action codes.
	localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_RX     = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_LISTEN = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ACK    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_BUSY   = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RSSI_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENSING_TICKS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_UNIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIALS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WATCHDOG_PERIOD = 3'd4;

	// Register reset values.
	localparam logic signed [RSSI_W-1:0] RST_RSSI_THRESHOLD = -9'sd80;
	localparam logic [SENSE_W-1:0]       RST_SENSING_TICKS  = 10'd5;
	localparam logic [UNIT_W-1:0]        RST_BACKOFF_UNIT   = 8'd10;
	localparam logic [TRLIM_W-1:0]       RST_MAX_TRIALS     = 4'd5;
	localparam logic [WDOG_W-1:0]        RST_WATCHDOG       = 16'd600;

	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_SENSE   = 4'b0010,
		MODE_BACKOFF = 4'b0100,
		MODE_WAIT_TX = 4'b1000
	} mode_t;

endpackage

@@ hdl/lbtack_in_if.sv @@
interface lbtack_in_if;
	logic                                      valid;
	logic                                      ready;
	logic [lbtack_pkg::CMD_W-1:0]              cmd;
	logic signed [lbtack_pkg::RSSI_W-1:0]      rssi_sample;
	logic [lbtack_pkg::RND_W-1:0]              random_byte;

	modport source (output valid, output cmd, output rssi_sample, output random_byte,
		input ready);
	modport sink (input valid, input cmd, input rssi_sample, input random_byte,
		output ready);
endinterface

@@ hdl/lbtack_out_if.sv @@
interface lbtack_out_if;
	logic                                valid;
	logic                                ready;
	logic [lbtack_pkg::ACTION_W-1:0]     action;
	logic [lbtack_pkg::TICKS_W-1:0]      backoff_ticks;
	logic                                pulse_rx_led;
	logic                                pulse_tx_led;
	logic                                pulse_error_led;
	logic                                reset_request;

	modport source (output valid, output action, output backoff_ticks,
		output pulse_rx_led, output pulse_tx_led, output pulse_error_led,
		output reset_request, input ready);
	modport sink (input valid, input action, input backoff_ticks,
		input pulse_rx_led, input pulse_tx_led, input pulse_error_led,
		input reset_request, output ready);
endinterface

@@ hdl/lbt_ack_responder_with_backoff_unit.sv @@
// An accepted item is held first in the input register and then in the result register,
// from which it is taken.
// Throughput: one item per cycle while results are taken. A waiting result holds the
// item in the input register, and the input then accepts nothing until the result moves.
// Reset (arst_n low) clears control state; the watchdog and registers load their defaults.
module lbt_ack_responder_with_backoff_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	lbtack_in_if.sink                            in_ch,
	lbtack_out_if.source                         out_ch,
	input  logic                                 cfg_we,
	input  logic [lbtack_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbtack_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned TW = lbtack_pkg::TRIAL_W;

	// Configuration registers.
	logic signed [lbtack_pkg::RSSI_W-1:0] rssi_threshold_q;
	logic [lbtack_pkg::SENSE_W-1:0]       sensing_ticks_q;
	logic [lbtack_pkg::UNIT_W-1:0]        backoff_unit_q;
	logic [lbtack_pkg::TRLIM_W-1:0]       max_trials_q;
	logic [lbtack_pkg::WDOG_W-1:0]        watchdog_period_q;

	// Block state.
	lbtack_pkg::mode_t                    mode_q, mode_d;
	logic [TW-1:0]                        trial_index_q, trial_index_d;
	logic [lbtack_pkg::SENSE_W-1:0]       sense_elapsed_q, sense_elapsed_d;
	logic [lbtack_pkg::TICKS_W-1:0]       backoff_left_q, backoff_left_d;
	logic [lbtack_pkg::WDOG_W-1:0]        watchdog_count_q, watchdog_count_d;

	// Input register.
	logic                                 valid_s1;
	logic [lbtack_pkg::CMD_W-1:0]         cmd_s1;
	logic signed [lbtack_pkg::RSSI_W-1:0] rssi_s1;
	logic [lbtack_pkg::RND_W-1:0]         rnd_s1;

	// Result register.
	logic                                 out_valid_q;
	logic [lbtack_pkg::ACTION_W-1:0]      action_q, action_d;
	logic [lbtack_pkg::TICKS_W-1:0]       bticks_q, bticks_d;
	logic                                 led_rx_q, led_rx_d;
	logic                                 led_tx_q, led_tx_d;
	logic                                 led_err_q, led_err_d;
	logic                                 rst_req_q, rst_req_d;

	logic                                 advance;
	logic [lbtack_pkg::TRLIM_W-1:0]       trial_limit;
	logic [lbtack_pkg::TRLIM_W-1:0]       trial_next;
	logic [lbtack_pkg::RND_W:0]           mask_wide;
	logic [lbtack_pkg::RND_W:0]           slots;
	logic [lbtack_pkg::UNIT_W+lbtack_pkg::RND_W:0] product;
	logic [lbtack_pkg::TICKS_W-1:0]       bticks_new;
	logic [lbtack_pkg::SENSE_W-1:0]       sense_inc;
	logic [lbtack_pkg::TICKS_W-1:0]       backoff_dec;

	// The input item moves on whenever the result register is free or being emptied.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rssi_threshold_q  <= lbtack_pkg::RST_RSSI_THRESHOLD;
			sensing_ticks_q   <= lbtack_pkg::RST_SENSING_TICKS;
			backoff_unit_q    <= lbtack_pkg::RST_BACKOFF_UNIT;
			max_trials_q      <= lbtack_pkg::RST_MAX_TRIALS;
			watchdog_period_q <= lbtack_pkg::RST_WATCHDOG;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbtack_pkg::REG_RSSI_THRESHOLD:  rssi_threshold_q  <= cfg_data[8:0];
				lbtack_pkg::REG_SENSING_TICKS:   sensing_ticks_q   <= cfg_data[9:0];
				lbtack_pkg::REG_BACKOFF_UNIT:    backoff_unit_q    <= cfg_data[7:0];
				lbtack_pkg::REG_MAX_TRIALS:      max_trials_q      <= cfg_data[3:0];
				lbtack_pkg::REG_WATCHDOG_PERIOD: watchdog_period_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1  <= in_ch.cmd;
			rssi_s1 <= in_ch.rssi_sample;
			rnd_s1  <= in_ch.random_byte;
		end
	end

	// Backoff length: unit * (1 + (rand mod 2^(trial+1))).
	always_comb begin
		if (max_trials_q == '0) begin
			trial_limit = lbtack_pkg::TRLIM_W'(1);
		end else if (max_trials_q > lbtack_pkg::TRLIM_W'(lbtack_pkg::TRIALS_BOUND)) begin
			trial_limit = lbtack_pkg::TRLIM_W'(lbtack_pkg::TRIALS_BOUND);
		end else begin
			trial_limit = max_trials_q;
		end
		trial_next  = {1'b0, trial_index_q} + lbtack_pkg::TRLIM_W'(1);
		mask_wide   = (9'd1 << trial_next) - 9'd1;
		slots       = {1'b0, rnd_s1 & mask_wide[lbtack_pkg::RND_W-1:0]} + 9'd1;
		product     = {9'd0, backoff_unit_q} * {8'd0, slots};
		bticks_new  = product[lbtack_pkg::TICKS_W-1:0];
		sense_inc   = sense_elapsed_q + 10'd1;
		backoff_dec = (backoff_left_q != '0) ? backoff_left_q - 15'd1 : backoff_left_q;
	end

	always_comb begin
		mode_d           = mode_q;
		trial_index_d    = trial_index_q;
		sense_elapsed_d  = sense_elapsed_q;
		backoff_left_d   = backoff_left_q;
		watchdog_count_d = watchdog_count_q;
		action_d         = lbtack_pkg::ACT_NONE;
		bticks_d         = '0;
		led_rx_d         = 1'b0;
		led_tx_d         = 1'b0;
		led_err_d        = 1'b0;
		rst_req_d        = 1'b0;
		unique case (cmd_s1)
			lbtack_pkg::CMD_MS_TICK: begin
				if (mode_q == lbtack_pkg::MODE_SENSE) begin
					if (rssi_s1 > rssi_threshold_q) begin
						if (trial_next < trial_limit) begin
							bticks_d      = bticks_new;
							trial_index_d = trial_next[TW-1:0];
							sense_elapsed_d = '0;
							if (bticks_new == '0) begin
								mode_d         = lbtack_pkg::MODE_SENSE;
								backoff_left_d = '0;
							end else begin
								mode_d         = lbtack_pkg::MODE_BACKOFF;
								backoff_left_d = bticks_new;
							end
						end else begin
							// Last trial was busy: report it and give up.
							action_d        = lbtack_pkg::ACT_BUSY;
							led_err_d       = 1'b1;
							mode_d          = lbtack_pkg::MODE_IDLE;
							trial_index_d   = '0;
							sense_elapsed_d = '0;
						end
					end else begin
						sense_elapsed_d = sense_inc;
						if (sense_inc >= sensing_ticks_q) begin
							action_d        = lbtack_pkg::ACT_ACK;
							mode_d          = lbtack_pkg::MODE_WAIT_TX;
							sense_elapsed_d = '0;
						end
					end
				end else if (mode_q == lbtack_pkg::MODE_BACKOFF) begin
					backoff_left_d = backoff_dec;
					if (backoff_dec == '0) begin
						mode_d          = lbtack_pkg::MODE_SENSE;
						sense_elapsed_d = '0;
					end
				end
			end
			lbtack_pkg::CMD_SEC_TICK: begin
				if (watchdog_count_q != '0) begin
					watchdog_count_d = watchdog_count_q - 16'd1;
				end else begin
					rst_req_d = 1'b1;
				end
			end
			lbtack_pkg::CMD_RX_DONE: begin
				watchdog_count_d = watchdog_period_q;
				led_rx_d         = 1'b1;
				trial_index_d    = '0;
				sense_elapsed_d  = '0;
				backoff_left_d   = '0;
				if (sensing_ticks_q == '0) begin
					action_d = lbtack_pkg::ACT_ACK;
					mode_d   = lbtack_pkg::MODE_WAIT_TX;
				end else begin
					action_d = lbtack_pkg::ACT_LISTEN;
					mode_d   = lbtack_pkg::MODE_SENSE;
				end
			end
			lbtack_pkg::CMD_RX_TIMEOUT, lbtack_pkg::CMD_RX_ERROR,
			lbtack_pkg::CMD_TX_DONE, lbtack_pkg::CMD_TX_TIMEOUT: begin
				led_err_d       = (cmd_s1 == lbtack_pkg::CMD_RX_ERROR) ||
					(cmd_s1 == lbtack_pkg::CMD_TX_TIMEOUT);
				led_tx_d        = (cmd_s1 == lbtack_pkg::CMD_TX_DONE);
				action_d        = lbtack_pkg::ACT_RX;
				mode_d          = lbtack_pkg::MODE_IDLE;
				trial_index_d   = '0;
				sense_elapsed_d = '0;
				backoff_left_d  = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= lbtack_pkg::MODE_IDLE;
			trial_index_q    <= '0;
			sense_elapsed_q  <= '0;
			backoff_left_q   <= '0;
			watchdog_count_q <= lbtack_pkg::RST_WATCHDOG;
		end else if (advance) begin
			mode_q           <= mode_d;
			trial_index_q    <= trial_index_d;
			sense_elapsed_q  <= sense_elapsed_d;
			backoff_left_q   <= backoff_left_d;
			watchdog_count_q <= watchdog_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q  <= action_d;
			bticks_q  <= bticks_d;
			led_rx_q  <= led_rx_d;
			led_tx_q  <= led_tx_d;
			led_err_q <= led_err_d;
			rst_req_q <= rst_req_d;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.action          = action_q;
	assign out_ch.backoff_ticks   = bticks_q;
	assign out_ch.pulse_rx_led    = led_rx_q;
	assign out_ch.pulse_tx_led    = led_tx_q;
	assign out_ch.pulse_error_led = led_err_q;
	assign out_ch.reset_request   = rst_req_q;

	// A backoff in progress always has ticks left to wait.
	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == lbtack_pkg::MODE_BACKOFF |-> backoff_left_q != '0)
		else $error("backoff mode with no ticks left");

	// Every way into idle clears the attempt counters.
	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == lbtack_pkg::MODE_IDLE |-> (trial_index_q == '0 && sense_elapsed_q == '0))
		else $error("idle with stale trial or sense count");

	// A busy report always lights the error indicator.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && action_q == lbtack_pkg::ACT_BUSY |-> led_err_q)
		else $error("channel busy without error pulse");

	// A chosen backoff is only reported on a result that orders nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bticks_q != '0 |-> action_q == lbtack_pkg::ACT_NONE)
		else $error("backoff reported alongside an action");

	// A result left waiting keeps the next item in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready && valid_s1 |=> valid_s1 && $stable(cmd_s1))
		else $error("input item dropped while result stalled");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import lbtack_pkg::*;

	// The command field is three bits wide; this code is left unused by the block.
	localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic signed [RSSI_W-1:0] rssi;
		logic [RND_W-1:0]         rnd;
	} lbt_event_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [TICKS_W-1:0]  backoff_ticks;
		logic                rx_led;
		logic                tx_led;
		logic                err_led;
		logic                rst_req;
	} lbt_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lbtack_in_if  in_ch();
	lbtack_out_if out_ch();

	lbt_ack_responder_with_backoff_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Register shadows, kept in step with every write.
	logic signed [RSSI_W-1:0] thr_cfg;
	logic [SENSE_W-1:0]       sense_cfg;
	logic [UNIT_W-1:0]        unit_cfg;
	logic [TRLIM_W-1:0]       trials_cfg;
	logic [WDOG_W-1:0]        wdog_period_cfg;

	// Controller state as the block should hold it.
	mode_t              ctl_mode;
	logic [TRIAL_W-1:0] trial_q;
	logic [SENSE_W-1:0] quiet_q;
	logic [TICKS_W-1:0] wait_left_q;
	logic [WDOG_W-1:0]  wdog_q;

	lbt_event_t  queued_events[$];
	lbt_result_t predicted_results[$];

	int unsigned issued_count;
	int unsigned accepted_count;
	int unsigned errors;
	int unsigned settings_count;
	int unsigned ack_seen, busy_seen, backoff_seen, wdog_seen;
	bit          in_fire;
	int unsigned burst_left;
	int unsigned gap_left;
	lbt_event_t  next_event;
	lbt_event_t  taken;
	lbt_result_t want;
	lbt_result_t fresh;
	logic [7:0]  stall_mask;
	logic [2:0]  stall_phase;

	task automatic step_controller(input lbt_event_t ev, output lbt_result_t res);
		int unsigned limit_now;
		int unsigned slots;
		int unsigned prod;
		logic [TICKS_W-1:0] span;
		res = '0;
		if (trials_cfg == 0)
			limit_now = 1;
		else if (trials_cfg > TRIALS_BOUND)
			limit_now = TRIALS_BOUND;
		else
			limit_now = trials_cfg;
		case (ev.cmd)
		CMD_MS_TICK: begin
			if (ctl_mode == MODE_SENSE) begin
				if ($signed(ev.rssi) > thr_cfg) begin
					if (trial_q + 1 < limit_now) begin
						// Slot count widens with each attempt: low trial+1 bits of the byte.
						slots = 1 + (ev.rnd & ((1 << (trial_q + 1)) - 1));
						prod = unit_cfg * slots;
						span = prod[TICKS_W-1:0];
						res.backoff_ticks = span;
						trial_q = trial_q + 1'b1;
						quiet_q = '0;
						if (span == 0) begin
							ctl_mode = MODE_SENSE;
							wait_left_q = '0;
						end else begin
							ctl_mode = MODE_BACKOFF;
							wait_left_q = span;
						end
					end else begin
						res.action = ACT_BUSY;
						res.err_led = 1'b1;
						ctl_mode = MODE_IDLE;
						trial_q = '0;
						quiet_q = '0;
					end
				end else begin
					quiet_q = quiet_q + 1'b1;
					if (quiet_q >= sense_cfg) begin
						res.action = ACT_ACK;
						ctl_mode = MODE_WAIT_TX;
						quiet_q = '0;
					end
				end
			end else if (ctl_mode == MODE_BACKOFF) begin
				if (wait_left_q != 0)
					wait_left_q = wait_left_q - 1'b1;
				if (wait_left_q == 0) begin
					ctl_mode = MODE_SENSE;
					quiet_q = '0;
				end
			end
		end
		CMD_SEC_TICK: begin
			if (wdog_q != 0)
				wdog_q = wdog_q - 1'b1;
			else
				res.rst_req = 1'b1;
		end
		CMD_RX_DONE: begin
			wdog_q = wdog_period_cfg;
			res.rx_led = 1'b1;
			trial_q = '0;
			quiet_q = '0;
			wait_left_q = '0;
			if (sense_cfg == 0) begin
				res.action = ACT_ACK;
				ctl_mode = MODE_WAIT_TX;
			end else begin
				res.action = ACT_LISTEN;
				ctl_mode = MODE_SENSE;
			end
		end
		CMD_RX_TIMEOUT, CMD_RX_ERROR, CMD_TX_DONE, CMD_TX_TIMEOUT: begin
			res.err_led = (ev.cmd == CMD_RX_ERROR) || (ev.cmd == CMD_TX_TIMEOUT);
			res.tx_led = (ev.cmd == CMD_TX_DONE);
			res.action = ACT_RX;
			ctl_mode = MODE_IDLE;
			trial_q = '0;
			quiet_q = '0;
			wait_left_q = '0;
		end
		default: ;
		endcase
	endtask

	function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v !== got_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	// Monitor: results are checked before this edge's input item is predicted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t ns: result with none expected, expected nothing, actual action %0d",
						$time, out_ch.action);
					errors++;
				end else begin
					want = predicted_results.pop_front();
					check_field("action", want.action, out_ch.action);
					check_field("backoff_ticks", want.backoff_ticks, out_ch.backoff_ticks);
					check_field("pulse_rx_led", want.rx_led, out_ch.pulse_rx_led);
					check_field("pulse_tx_led", want.tx_led, out_ch.pulse_tx_led);
					check_field("pulse_error_led", want.err_led, out_ch.pulse_error_led);
					check_field("reset_request", want.rst_req, out_ch.reset_request);
				end
				if (out_ch.action == ACT_ACK) ack_seen++;
				if (out_ch.action == ACT_BUSY) busy_seen++;
				if (out_ch.backoff_ticks != 0) backoff_seen++;
				if (out_ch.reset_request) wdog_seen++;
			end
			in_fire = in_ch.valid && in_ch.ready;
			if (in_fire) begin
				taken.cmd = in_ch.cmd;
				taken.rssi = in_ch.rssi_sample;
				taken.rnd = in_ch.random_byte;
				step_controller(taken, fresh);
				predicted_results.push_back(fresh);
				accepted_count++;
			end
		end else begin
			in_fire = 1'b0;
		end
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (queued_events.size() > 0) begin
				next_event = queued_events.pop_front();
				issued_count++;
				in_ch.valid <= 1'b1;
				in_ch.cmd <= next_event.cmd;
				in_ch.rssi_sample <= next_event.rssi;
				in_ch.random_byte <= next_event.rnd;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: a random eight-bit ready mask, read one bit at a time, redrawn each time it runs out.
	always @(negedge clk) begin
		if (stall_phase == 0)
			stall_mask = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255));
		out_ch.ready <= stall_mask[stall_phase];
		stall_phase = stall_phase + 1'b1;
	end

	task automatic add_event(input int cmd, input int rssi, input int rnd);
		lbt_event_t ev;
		ev.cmd = CMD_W'(cmd);
		ev.rssi = RSSI_W'(rssi);
		ev.rnd = RND_W'(rnd);
		queued_events.push_back(ev);
	endtask

	function automatic logic [RSSI_W-1:0] pick_rssi(bit busy);
		int thr;
		int lo;
		int hi;
		thr = thr_cfg;
		if (busy) begin
			lo = thr + 1;
			hi = 20;
		end else begin
			lo = -140;
			hi = thr;
		end
		if (lo > hi) lo = hi;
		return RSSI_W'(lo + int'($urandom_range(hi - lo)));
	endfunction

	// Mostly complete exchanges (frame in, sensing ticks, radio event) plus raw noise.
	task automatic queue_sessions(int unsigned budget);
		int unsigned made;
		int unsigned ticks;
		int unsigned busy_pct;
		int unsigned k;
		made = 0;
		while (made < budget) begin
			if ($urandom_range(99) < 12) begin
				add_event($urandom_range(7), $urandom_range(511), $urandom_range(255));
				made++;
			end else begin
				add_event(CMD_RX_DONE, $urandom_range(511), $urandom_range(255));
				ticks = $urandom_range(1, 80);
				// Keep the phase close to its item budget.
				if (made + ticks + 2 > budget)
					ticks = (budget > made + 2) ? budget - made - 2 : 1;
				busy_pct = $urandom_range(0, 60);
				for (k = 0; k < ticks; k++) begin
					if ($urandom_range(15) == 0)
						add_event(CMD_SEC_TICK, $urandom_range(511), $urandom_range(255));
					else
						add_event(CMD_MS_TICK, pick_rssi($urandom_range(99) < busy_pct),
							$urandom_range(255));
				end
				made += ticks + 1;
				case ($urandom_range(5))
				0: add_event(CMD_TX_DONE, $urandom_range(511), $urandom_range(255));
				1: add_event(CMD_TX_TIMEOUT, $urandom_range(511), $urandom_range(255));
				2: add_event(CMD_RX_TIMEOUT, $urandom_range(511), $urandom_range(255));
				3: add_event(CMD_RX_ERROR, $urandom_range(511), $urandom_range(255));
				default: ;
				endcase
				made++;
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(data);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_RSSI_THRESHOLD:  thr_cfg = RSSI_W'(data);
		REG_SENSING_TICKS:   sense_cfg = SENSE_W'(data);
		REG_BACKOFF_UNIT:    unit_cfg = UNIT_W'(data);
		REG_MAX_TRIALS:      trials_cfg = TRLIM_W'(data);
		REG_WATCHDOG_PERIOD: wdog_period_cfg = WDOG_W'(data);
		default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (!(queued_events.size() == 0 && issued_count == accepted_count
			&& predicted_results.size() == 0))
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(int thr, int sense, int unit, int trials, int wd,
		int unsigned budget);
		wait_idle();
		write_reg(REG_RSSI_THRESHOLD, thr);
		write_reg(REG_SENSING_TICKS, sense);
		write_reg(REG_BACKOFF_UNIT, unit);
		write_reg(REG_MAX_TRIALS, trials);
		write_reg(REG_WATCHDOG_PERIOD, wd);
		settings_count++;
		queue_sessions(budget);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.rssi_sample = '0;
		in_ch.random_byte = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_phase = '0;
		stall_mask = '0;
		in_fire = 1'b0;
		burst_left = 1;
		gap_left = 0;
		thr_cfg = RST_RSSI_THRESHOLD;
		sense_cfg = RST_SENSING_TICKS;
		unit_cfg = RST_BACKOFF_UNIT;
		trials_cfg = RST_MAX_TRIALS;
		wdog_period_cfg = RST_WATCHDOG;
		ctl_mode = MODE_IDLE;
		trial_q = '0;
		quiet_q = '0;
		wait_left_q = '0;
		wdog_q = RST_WATCHDOG;
		settings_count = 1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings, every command, field extremes.
		add_event(CMD_SEC_TICK, -140, 8'd0);
		add_event(CMD_RESERVED, 9'h1FF, 8'hFF);
		add_event(CMD_MS_TICK, 20, 8'hFF);
		add_event(CMD_RX_DONE, 0, 8'd0);
		repeat (4) add_event(CMD_MS_TICK, -140, 8'd0);
		// A sample equal to the threshold still counts as quiet.
		add_event(CMD_MS_TICK, -80, 8'h55);
		add_event(CMD_TX_DONE, 0, 8'd0);
		add_event(CMD_RX_DONE, 0, 8'd0);
		add_event(CMD_MS_TICK, 20, 8'hFF);
		add_event(CMD_MS_TICK, -79, 8'hAA);
		add_event(CMD_RX_TIMEOUT, 0, 8'd0);
		add_event(CMD_RX_ERROR, 0, 8'd0);
		add_event(CMD_TX_TIMEOUT, 0, 8'd0);
		add_event(CMD_MS_TICK, 9'h0FF, 8'd0);
		wait_idle();

		// Zero sensing window acknowledges at once; zero unit gives no backoff wait.
		write_reg(REG_SENSING_TICKS, 0);
		write_reg(REG_BACKOFF_UNIT, 0);
		write_reg(REG_MAX_TRIALS, 2);
		settings_count++;
		add_event(CMD_RX_DONE, 0, 8'd0);
		add_event(CMD_TX_DONE, 0, 8'd0);
		wait_idle();
		write_reg(REG_SENSING_TICKS, 2);
		add_event(CMD_RX_DONE, 0, 8'd0);
		add_event(CMD_MS_TICK, 0, 8'hFF);
		add_event(CMD_MS_TICK, 20, 8'hFF);

		run_phase(-140, 1, 1, 8, 3, 150);
		run_phase(0, 2, 0, 1, 0, 120);
		run_phase(-60, 0, 255, 0, 65535, 100);
		run_phase(-90, 3, 2, 15, 5, 150);
		run_phase(-100, 1023, 1, 4, 10, 60);
		repeat (6)
			run_phase(-int'($urandom_range(140)), $urandom_range(1, 6), $urandom_range(1, 3),
				$urandom_range(1, 8), $urandom_range(0, 6), 145);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("Ran %0d items under %0d register settings: %0d ACK orders, %0d busy reports,",
			accepted_count, settings_count, ack_seen, busy_seen);
		$display("%0d backoffs chosen and %0d watchdog reset requests; %0d mismatches.",
			backoff_seen, wdog_seen, errors);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t ns: run did not finish in time", $time);
		$display("tb_top: errors");
		$finish;
	end

endmodule
